// ===== design/urmf_pkg.sv =====
// ----------------------------------------------------------------------------
// urmf_pkg
// shared constants for the uart receive message store: register indexes,
// operation and status codes, reset values
// ----------------------------------------------------------------------------
package urmf_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;

    localparam logic [LEN_W-1:0]  MSG_LEN_RESET = 6'd8;
    localparam logic [BYTE_W-1:0] DELIM_RESET   = 8'd10;
    localparam logic [LEN_W-1:0]  MSG_LEN_MIN   = 6'd2;

    localparam logic CFG_MSG_LEN = 1'b0;
    localparam logic CFG_DELIM   = 1'b1;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [STAT_W-1:0] ST_GOOD  = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] ST_DELIM = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DATA  = 3'b010,
        S_SHORT = 3'b100
    } t_state;

endpackage

// ===== design/uart_rx_message_fifo.sv =====
// ----------------------------------------------------------------------------
// uart_rx_message_fifo
// circular byte store for received bytes, drained in whole fixed-length
// messages with a check for misplaced delimiter bytes
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  in       | input     | i_in_valid / o_in_stall | i_op, i_rx_byte
//  out      | output    | o_out_valid / i_out_stall | o_data_byte, o_status, o_last
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  a store item does not stall the input; the next item is accepted in the next cycle.
//  a read item emits its result bytes from the ram's single read port, which
//  sets the pace of one byte per cycle while the output is not stalled.
//  the input stalls while a read item is being emitted; output stall holds
//  the output register and pauses the read.
//  reset is synchronous and empties the store; no clearing pass is needed.
// ----------------------------------------------------------------------------
module uart_rx_message_fifo #(
    parameter int STORE_DEPTH = urmf_pkg::STORE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [urmf_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [urmf_pkg::BYTE_W-1:0]   o_data_byte,
    output logic [urmf_pkg::STAT_W-1:0]   o_status,
    output logic                          o_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [urmf_pkg::BYTE_W-1:0]   i_cfg_data
);

    localparam int PW = $clog2(STORE_DEPTH);
    localparam int CW = PW + 1;
    localparam int KW = (CW > urmf_pkg::LEN_W) ? CW : urmf_pkg::LEN_W;

    urmf_pkg::t_state r_state, n_state;

    logic [PW-1:0]                 r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]                 r_rem, n_rem;
    logic [urmf_pkg::LEN_W-1:0]    r_pos, n_pos;
    logic [urmf_pkg::LEN_W-1:0]    r_msg_len;
    logic [urmf_pkg::BYTE_W-1:0]   r_delim;

    logic                          r_out_valid, n_out_valid;
    logic [urmf_pkg::BYTE_W-1:0]   r_data, n_data;
    logic [urmf_pkg::STAT_W-1:0]   r_stat, n_stat;
    logic                          r_last, n_last;

    logic                          in_acc, out_free, wr_en;
    logic [PW-1:0]                 wp_next, rp_next, rd_addr;
    logic [urmf_pkg::BYTE_W-1:0]   rd_data;
    logic [urmf_pkg::LEN_W-1:0]    len;
    logic [CW-1:0]                 avail, rem_dec;
    logic                          pos_end, msg_end;

    assign o_in_stall  = (r_state != urmf_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign wp_next = (r_wp == PW'(STORE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rp_next = (r_rp == PW'(STORE_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    assign wr_en = in_acc && (i_op == urmf_pkg::OP_STORE) && (wp_next != r_rp);

    assign len   = (r_msg_len < urmf_pkg::MSG_LEN_MIN) ? urmf_pkg::MSG_LEN_MIN : r_msg_len;
    assign avail = {1'b0, r_wp} - {1'b0, r_rp} + ((r_wp < r_rp) ? CW'(STORE_DEPTH) : '0);

    assign rem_dec = r_rem - 1'b1;
    assign pos_end = (r_pos == len - 1'b1);
    assign msg_end = pos_end && (KW'(rem_dec) < KW'(len));

    assign rd_addr = ((r_state == urmf_pkg::S_DATA) && out_free) ? rp_next : r_rp;

    urmf_ram #(
        .WIDTH (urmf_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_data      = r_data;
        n_stat      = r_stat;
        n_last      = r_last;

        unique case (r_state)
            urmf_pkg::S_IDLE: begin
                if (wr_en) begin
                    n_wp = wp_next;
                end
                if (in_acc && (i_op == urmf_pkg::OP_READ)) begin
                    n_rem = avail;
                    n_pos = '0;
                    if (KW'(avail) > KW'(len)) begin
                        n_state = urmf_pkg::S_DATA;
                    end else begin
                        n_state = urmf_pkg::S_SHORT;
                    end
                end
            end
            urmf_pkg::S_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_data      = rd_data;
                    n_rp        = rp_next;
                    n_rem       = rem_dec;
                    n_pos       = pos_end ? '0 : r_pos + 1'b1;
                    if (!pos_end && (rd_data == r_delim)) begin
                        n_stat  = urmf_pkg::ST_DELIM;
                        n_last  = 1'b1;
                        n_state = urmf_pkg::S_IDLE;
                    end else begin
                        n_stat = urmf_pkg::ST_GOOD;
                        n_last = msg_end;
                        if (msg_end) begin
                            n_state = urmf_pkg::S_IDLE;
                        end
                    end
                end
            end
            urmf_pkg::S_SHORT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_data      = '0;
                    n_stat      = urmf_pkg::ST_SHORT;
                    n_last      = 1'b1;
                    n_state     = urmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = urmf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= urmf_pkg::S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
            r_msg_len   <= urmf_pkg::MSG_LEN_RESET;
            r_delim     <= urmf_pkg::DELIM_RESET;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == urmf_pkg::CFG_MSG_LEN) begin
                    r_msg_len <= i_cfg_data[urmf_pkg::LEN_W-1:0];
                end else begin
                    r_delim <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_pos  <= n_pos;
        r_data <= n_data;
        r_stat <= n_stat;
        r_last <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_data;
    assign o_status    = r_stat;
    assign o_last      = r_last;

endmodule

// ===== design/urmf_ram.sv =====
// ----------------------------------------------------------------------------
// urmf_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module urmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/urmf_checker.sv =====
// ----------------------------------------------------------------------------
// urmf_checker
// port-level checks for the uart receive message store, bound to the top
// ----------------------------------------------------------------------------
module urmf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          i_op,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [urmf_pkg::BYTE_W-1:0]   o_data_byte,
    input  logic [urmf_pkg::STAT_W-1:0]   o_status,
    input  logic                          o_last
);

    // short answer is a single empty item
    a_short_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == urmf_pkg::ST_SHORT)) |-> (o_last && (o_data_byte == '0)))
        else $error("short answer not a single empty item");

    // a misplaced delimiter ends the read
    a_delim_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == urmf_pkg::ST_DELIM)) |-> o_last)
        else $error("delimiter error without last");

    // an accepted read always holds off the input while it answers
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_op == urmf_pkg::OP_READ)) |=> o_in_stall)
        else $error("input taken during a read");

    // a stalled item stays put
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_data_byte)
            && $stable(o_status) && $stable(o_last)))
        else $error("stalled item changed");

    // output stage empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind uart_rx_message_fifo urmf_checker u_urmf_checker (.*);

// ===== bench/tb_uart_rx_message_fifo.sv =====
// ----------------------------------------------------------------------------
// tb_uart_rx_message_fifo
// drives stored bytes and read requests into the message store, predicts
// every result byte with a copy of the store and its pointers, and checks
// each result in order; idling, stalls and register settings vary by phase
// ----------------------------------------------------------------------------
module tb_uart_rx_message_fifo;

    localparam int DEPTH       = urmf_pkg::STORE_DEPTH_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_ITEMS = 20;

    typedef struct packed {
        logic                        op;
        logic [urmf_pkg::BYTE_W-1:0] rx_byte;
        logic                        hold;
    } t_rx_item;

    typedef struct packed {
        logic [urmf_pkg::BYTE_W-1:0] data_byte;
        logic [urmf_pkg::STAT_W-1:0] status;
        logic                        last;
    } t_result;

    typedef struct packed {
        logic                        index;
        logic [urmf_pkg::BYTE_W-1:0] data;
    } t_setting;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        i_op        = urmf_pkg::OP_STORE;
    logic [urmf_pkg::BYTE_W-1:0] i_rx_byte   = '0;
    logic                        i_out_stall = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        i_cfg_index = urmf_pkg::CFG_MSG_LEN;
    logic [urmf_pkg::BYTE_W-1:0] i_cfg_data  = '0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [urmf_pkg::BYTE_W-1:0] o_data_byte;
    logic [urmf_pkg::STAT_W-1:0] o_status;
    logic                        o_last;
    logic                        o_cfg_ready;

    t_rx_item pending_items[$];
    t_result  expected_bytes[$];
    t_setting setting_writes[$];

    logic [urmf_pkg::BYTE_W-1:0] store_copy [DEPTH];
    int                          wr_ptr = 0;
    int                          rd_ptr = 0;
    logic [urmf_pkg::LEN_W-1:0]  msg_len = urmf_pkg::MSG_LEN_RESET;
    logic [urmf_pkg::BYTE_W-1:0] delim   = urmf_pkg::DELIM_RESET;

    logic [urmf_pkg::BYTE_W-1:0] first_msg  [9] = '{8'h00, 8'hFF, 8'h11, 8'h22, 8'h33,
                                                   8'h44, 8'h55, 8'h0A, 8'h66};
    logic [urmf_pkg::BYTE_W-1:0] second_msg [7] = '{8'h01, 8'h02, 8'h0A, 8'h03, 8'h04,
                                                   8'h05, 8'h06};
    logic [urmf_pkg::BYTE_W-1:0] len_set    [8] = '{8'd2, 8'd32, 8'd0, 8'd1, 8'd63,
                                                   8'hC5, 8'd40, 8'd3};
    logic [urmf_pkg::BYTE_W-1:0] delim_set  [8] = '{8'd0, 8'd255, 8'h55, 8'd0, 8'd0,
                                                   8'd10, 8'd0, 8'd0};

    int send_idle_pct  = 23;
    int recv_stall_pct = 85;
    int queued_count   = 0;
    int quiet_cycles   = 0;
    bit failed         = 1'b0;

    uart_rx_message_fifo u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_byte (o_data_byte),
        .o_status    (o_status),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int message_bytes();
        return (msg_len < urmf_pkg::MSG_LEN_MIN) ? int'(urmf_pkg::MSG_LEN_MIN)
                                                 : int'(msg_len);
    endfunction

    function automatic logic [urmf_pkg::BYTE_W-1:0] plain_byte();
        logic [urmf_pkg::BYTE_W-1:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == delim);
        return b;
    endfunction

    task automatic fifo_store_or_read(input logic op, input logic [urmf_pkg::BYTE_W-1:0] rx);
        int len;
        int waiting;
        int total;
        int nxt;
        logic [urmf_pkg::BYTE_W-1:0] b;
        if (op == urmf_pkg::OP_STORE) begin
            nxt = (wr_ptr + 1) % DEPTH;
            if (nxt != rd_ptr) begin
                store_copy[wr_ptr] = rx;
                wr_ptr = nxt;
            end
            return;
        end
        len = message_bytes();
        waiting = (wr_ptr - rd_ptr + DEPTH) % DEPTH;
        if (waiting <= len) begin
            expected_bytes.push_back(t_result'{8'd0, urmf_pkg::ST_SHORT, 1'b1});
            return;
        end
        total = (waiting / len) * len;
        for (int i = 0; i < total; i++) begin
            b = store_copy[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            if ((i % len) != len - 1 && b == delim) begin
                expected_bytes.push_back(t_result'{b, urmf_pkg::ST_DELIM, 1'b1});
                return;
            end
            expected_bytes.push_back(t_result'{b, urmf_pkg::ST_GOOD, (i + 1 == total)});
        end
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_in
        logic present;
        if (i_rst_n) begin
            present = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                fifo_store_or_read(i_op, i_rx_byte);
                void'(pending_items.pop_front());
                present = 1'b0;
            end
            if (!present && pending_items.size() != 0
                    && !(pending_items[0].hold && expected_bytes.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                present = 1'b1;
                i_op      <= pending_items[0].op;
                i_rx_byte <= pending_items[0].rx_byte;
            end
            i_in_valid <= present;
        end
    end

    // register write driver
    always @(posedge i_clk) begin : drive_cfg
        logic present;
        if (i_rst_n) begin
            present = i_cfg_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == urmf_pkg::CFG_MSG_LEN)
                    msg_len = i_cfg_data[urmf_pkg::LEN_W-1:0];
                else
                    delim = i_cfg_data;
                void'(setting_writes.pop_front());
                present = 1'b0;
            end
            if (!present && setting_writes.size() != 0) begin
                present = 1'b1;
                i_cfg_index <= setting_writes[0].index;
                i_cfg_data  <= setting_writes[0].data;
            end
            i_cfg_valid <= present;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : watch_out
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result: data %h status %0d last %0d",
                             $time, o_data_byte, o_status, o_last);
                    failed = 1'b1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_data_byte !== want.data_byte || o_status !== want.status
                            || o_last !== want.last) begin
                        $display({"%0t: expected data %h status %0d last %0d, ",
                                  "got data %h status %0d last %0d"},
                                 $time, want.data_byte, want.status, want.last,
                                 o_data_byte, o_status, o_last);
                        failed = 1'b1;
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    task automatic queue_item(input logic op, input logic [urmf_pkg::BYTE_W-1:0] rx,
                              input logic hold = 1'b0);
        pending_items.push_back(t_rx_item'{op, rx, hold});
        queued_count++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_bytes.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_setting(input logic [urmf_pkg::BYTE_W-1:0] len_data,
                                 input logic [urmf_pkg::BYTE_W-1:0] delim_data);
        setting_writes.push_back(t_setting'{urmf_pkg::CFG_MSG_LEN, len_data});
        setting_writes.push_back(t_setting'{urmf_pkg::CFG_DELIM, delim_data});
        while (setting_writes.size() != 0 || i_cfg_valid) @(posedge i_clk);
    endtask

    // whole messages with random content, a few stray delimiters and one to three trailing plain bytes, then a read
    task automatic queue_messages();
        int len;
        int count;
        logic [urmf_pkg::BYTE_W-1:0] b;
        len = message_bytes();
        count = $urandom_range(1, (len >= 30) ? 1 : 60 / len);
        for (int m = 0; m < count; m++) begin
            for (int pos = 0; pos < len; pos++) begin
                if (pos == len - 1)
                    b = $urandom_range(0, 1) ? delim : plain_byte();
                else if ($urandom_range(0, 99) < 4)
                    b = delim;
                else
                    b = plain_byte();
                queue_item(urmf_pkg::OP_STORE, b);
            end
        end
        repeat ($urandom_range(1, 3)) queue_item(urmf_pkg::OP_STORE, plain_byte());
        queue_item(urmf_pkg::OP_READ, 8'($urandom_range(0, 255)),
                   $urandom_range(0, 9) == 0);
    endtask

    task automatic queue_random_phase(input int n_items);
        int start;
        int r;
        start = queued_count;
        while (queued_count - start < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                queue_messages();
            end else if (r < 75) begin
                queue_item(urmf_pkg::OP_READ, 8'($urandom_range(0, 255)));
            end else if (r < 82) begin
                repeat ($urandom_range(60, 70)) queue_item(urmf_pkg::OP_STORE, plain_byte());
                queue_item(urmf_pkg::OP_READ, 8'($urandom_range(0, 255)));
            end else begin
                queue_item(urmf_pkg::OP_STORE, $urandom_range(0, 4) == 0
                                               ? delim : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : stimulus
        logic [urmf_pkg::BYTE_W-1:0] d;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, then a clean read with the delimiter closing a message
        queue_item(urmf_pkg::OP_READ, 8'hFF);
        foreach (first_msg[i]) queue_item(urmf_pkg::OP_STORE, first_msg[i]);
        queue_item(urmf_pkg::OP_READ, 8'h00);
        // exactly one message waiting is not enough
        foreach (second_msg[i]) queue_item(urmf_pkg::OP_STORE, second_msg[i]);
        queue_item(urmf_pkg::OP_READ, 8'hFF);
        // delimiter inside a message ends the read
        queue_item(urmf_pkg::OP_STORE, 8'h07);
        queue_item(urmf_pkg::OP_READ, 8'h5A, 1'b1);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            if (p < 3) begin
                send_idle_pct  = 23;
                recv_stall_pct = 85;
            end else if (p < 6) begin
                send_idle_pct  = 85;
                recv_stall_pct = 23;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            d = (p >= 3 && p != 5) ? 8'($urandom_range(0, 255)) : delim_set[p];
            queue_setting(len_set[p], d);
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (!failed)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/urmf_pkg.sv
design/urmf_ram.sv
design/uart_rx_message_fifo.sv
design/urmf_checker.sv
bench/tb_uart_rx_message_fifo.sv
